[rtl/core/w256m_pkg.sv]
// ----------------------------------------------------------------------------
// w256m_pkg - shared types and constants for the 256-bit multiplier core
// Word geometry and the record that travels down the chain of row cells.
// ----------------------------------------------------------------------------
package w256m_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned NWORDS  = 4;
  localparam int unsigned OPND_W  = NWORDS * WORD_W;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned ROW_W   = OPND_W + WORD_W;

  // action codes
  localparam logic ACT_FULL = 1'b0;
  localparam logic ACT_LOW  = 1'b1;

  typedef logic [NWORDS-1:0][WORD_W-1:0] opnd_t;

  // Record handed from one row cell to the next. b is consumed from its top
  // word; acc holds the partial sum of the rows done so far.
  typedef struct packed {
    logic              low_mode;
    opnd_t             a;
    opnd_t             b;
    logic [PROD_W-1:0] acc;
  } pass_t;

endpackage

[rtl/core/w256m_in_if.sv]
// ----------------------------------------------------------------------------
// w256m_in_if - operand channel
// Valid/ready channel carrying the mode bit and both 256-bit operands.
// ----------------------------------------------------------------------------
interface w256m_in_if;

  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] a_word0;
  logic [63:0] a_word1;
  logic [63:0] a_word2;
  logic [63:0] a_word3;
  logic [63:0] b_word0;
  logic [63:0] b_word1;
  logic [63:0] b_word2;
  logic [63:0] b_word3;

  modport source (
    output valid, action, a_word0, a_word1, a_word2, a_word3,
           b_word0, b_word1, b_word2, b_word3,
    input  ready
  );

  modport sink (
    input  valid, action, a_word0, a_word1, a_word2, a_word3,
           b_word0, b_word1, b_word2, b_word3,
    output ready
  );

endinterface

[rtl/core/w256m_out_if.sv]
// ----------------------------------------------------------------------------
// w256m_out_if - product channel
// Valid/ready channel carrying the eight 64-bit words of the product.
// ----------------------------------------------------------------------------
interface w256m_out_if;

  logic        valid;
  logic        ready;
  logic [63:0] p_word0;
  logic [63:0] p_word1;
  logic [63:0] p_word2;
  logic [63:0] p_word3;
  logic [63:0] p_word4;
  logic [63:0] p_word5;
  logic [63:0] p_word6;
  logic [63:0] p_word7;

  modport source (
    output valid, p_word0, p_word1, p_word2, p_word3,
           p_word4, p_word5, p_word6, p_word7,
    input  ready
  );

  modport sink (
    input  valid, p_word0, p_word1, p_word2, p_word3,
           p_word4, p_word5, p_word6, p_word7,
    output ready
  );

endinterface

[rtl/core/w256m_cell.sv]
// ----------------------------------------------------------------------------
// w256m_cell - one row of the schoolbook product
// Multiplies a by the top word of b and folds the row into the accumulator:
// acc' = (acc << 64) + a * b_top. Four register stages, one transaction per
// cycle; a stage holds only when it is full and the next stage holds.
// ----------------------------------------------------------------------------
module w256m_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  w256m_pkg::pass_t  in_data,
  output logic              in_en,
  output logic              out_valid,
  output w256m_pkg::pass_t  out_data,
  input  logic              out_en
);

  localparam int unsigned WW = w256m_pkg::WORD_W;
  localparam int unsigned HW = w256m_pkg::HALF_W;
  localparam int unsigned NW = w256m_pkg::NWORDS;
  localparam int unsigned PW = w256m_pkg::PROD_W;
  localparam int unsigned RW = w256m_pkg::ROW_W;

  // four 32x32 products per word: ll, lh, hl, hh
  typedef logic [3:0][WW-1:0]   quad_t;
  typedef logic [2*WW-1:0]      dword_t;

  logic             v1_r, v2_r, v3_r, v4_r;
  logic             e1, e2, e3, e4;
  w256m_pkg::pass_t d1_r, d2_r, d3_r, d4_r;
  w256m_pkg::pass_t d4_nxt;
  quad_t            prod_r   [NW];
  quad_t            prod_nxt [NW];
  dword_t           pw_r     [NW];
  dword_t           pw_nxt   [NW];
  logic [RW-1:0]    row_r, row_nxt;
  logic [WW-1:0]    bw;

  assign e4    = !v4_r || out_en;
  assign e3    = !v3_r || e4;
  assign e2    = !v2_r || e3;
  assign e1    = !v1_r || e2;
  assign in_en = e1;

  assign bw = in_data.b[NW-1];

  // stage 1: 32x32 partial products
  always_comb begin
    for (int j = 0; j < NW; j++) begin
      prod_nxt[j][0] = WW'(in_data.a[j][HW-1:0])  * WW'(bw[HW-1:0]);
      prod_nxt[j][1] = WW'(in_data.a[j][HW-1:0])  * WW'(bw[WW-1:HW]);
      prod_nxt[j][2] = WW'(in_data.a[j][WW-1:HW]) * WW'(bw[HW-1:0]);
      prod_nxt[j][3] = WW'(in_data.a[j][WW-1:HW]) * WW'(bw[WW-1:HW]);
    end
  end

  // stage 2: 64x64 word products
  always_comb begin
    for (int j = 0; j < NW; j++) begin
      pw_nxt[j] = {prod_r[j][3], prod_r[j][0]}
                + {{HW{1'b0}}, prod_r[j][1], {HW{1'b0}}}
                + {{HW{1'b0}}, prod_r[j][2], {HW{1'b0}}};
    end
  end

  // stage 3: row sum, even words side by side plus odd words one word up
  assign row_nxt = {{WW{1'b0}}, pw_r[2], pw_r[0]} + {pw_r[3], pw_r[1], {WW{1'b0}}};

  // stage 4: shift accumulator up one word and add the row
  always_comb begin
    d4_nxt     = d3_r;
    d4_nxt.acc = {d3_r.acc[PW-WW-1:0], {WW{1'b0}}} + {{(PW-RW){1'b0}}, row_r};
    d4_nxt.b   = {d3_r.b[NW-2:0], {WW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (e1) v1_r <= in_valid;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e1 && in_valid) begin
      d1_r   <= in_data;
      prod_r <= prod_nxt;
    end
    if (e2 && v1_r) begin
      d2_r <= d1_r;
      pw_r <= pw_nxt;
    end
    if (e3 && v2_r) begin
      d3_r  <= d2_r;
      row_r <= row_nxt;
    end
    if (e4 && v3_r) begin
      d4_r <= d4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_en |=> v1_r)
    else $error("cell dropped an incoming transaction");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && e2 |=> v2_r)
    else $error("cell lost a transaction between stages");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_en |=> v4_r && $stable(d4_r))
    else $error("cell output changed while stalled");

endmodule

[rtl/core/wide_256_multiplier_core.sv]
// ----------------------------------------------------------------------------
// wide_256_multiplier_core - pipelined 256 x 256 bit unsigned multiplier
// Four row cells in a chain, one per word of b, then an output register.
//
//   channel | dir | payload                          | handshake
//   in_if   | in  | action, a_word0..3, b_word0..3   | valid/ready
//   out_if  | out | p_word0..7                       | valid/ready
//
// One transaction per cycle sustained while out_if.ready is high; 17 registers
// from in_if to out_if.valid (4 cells of 4 stages - 32x32 products,
// 128-bit word sum, 320-bit row sum, 512-bit accumulate - then the output
// register; the first loads on the accepting edge). Reset clears valid bits only.
// A stage holds only when full and blocked downstream, so bubbles close up
// and operands are still taken while a finished product waits on out_if.
// ----------------------------------------------------------------------------
module wide_256_multiplier_core (
  input  logic               clk,
  input  logic               rst_n,
  w256m_in_if.sink           in_if,
  w256m_out_if.source        out_if
);

  localparam int unsigned NW = w256m_pkg::NWORDS;
  localparam int unsigned PW = w256m_pkg::PROD_W;
  localparam int unsigned OW = w256m_pkg::OPND_W;

  w256m_pkg::pass_t  lk_data  [NW+1];
  logic              lk_valid [NW+1];
  logic              lk_en    [NW+1];

  logic              out_valid_r;
  logic [PW-1:0]     p_r, p_nxt;

  always_comb begin
    lk_data[0]          = '0;
    lk_data[0].low_mode = in_if.action;
    lk_data[0].a        = {in_if.a_word3, in_if.a_word2, in_if.a_word1, in_if.a_word0};
    lk_data[0].b        = {in_if.b_word3, in_if.b_word2, in_if.b_word1, in_if.b_word0};
  end
  assign lk_valid[0] = in_if.valid;
  assign in_if.ready = lk_en[0];

  for (genvar i = 0; i < NW; i++) begin : g_cell
    w256m_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lk_valid[i]),
      .in_data   (lk_data[i]),
      .in_en     (lk_en[i]),
      .out_valid (lk_valid[i+1]),
      .out_data  (lk_data[i+1]),
      .out_en    (lk_en[i+1])
    );
  end

  assign lk_en[NW] = !out_valid_r || out_if.ready;

  always_comb begin
    p_nxt = lk_data[NW].acc;
    if (lk_data[NW].low_mode == w256m_pkg::ACT_LOW) begin
      p_nxt[PW-1:OW] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lk_en[NW]) begin
      out_valid_r <= lk_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_en[NW] && lk_valid[NW]) begin
      p_r <= p_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.p_word0 = p_r[63:0];
  assign out_if.p_word1 = p_r[127:64];
  assign out_if.p_word2 = p_r[191:128];
  assign out_if.p_word3 = p_r[255:192];
  assign out_if.p_word4 = p_r[319:256];
  assign out_if.p_word5 = p_r[383:320];
  assign out_if.p_word6 = p_r[447:384];
  assign out_if.p_word7 = p_r[511:448];

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    lk_valid[NW] && lk_en[NW] && (lk_data[NW].low_mode == w256m_pkg::ACT_LOW)
    |=> out_valid_r && (p_r[PW-1:OW] == '0))
    else $error("low mode product has nonzero upper words");

endmodule

[tb/sv/w256m_product_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w256m_product_checker - product prediction and comparison
// Watches both channels of the multiplier. Every operand transaction yields
// one expected 512-bit product, formed row by row from 64x64 partial
// products. Every product transaction is compared word by word against the
// oldest expected product.
// ----------------------------------------------------------------------------
module w256m_product_checker (
  input  logic        clk,
  input  logic        rst_n,
  w256m_in_if         in_ch,
  w256m_out_if        out_ch,
  output int unsigned n_fail,
  output int unsigned n_pending
);

  typedef logic [2*w256m_pkg::NWORDS-1:0][w256m_pkg::WORD_W-1:0] prod_t;
  typedef logic [2*w256m_pkg::WORD_W-1:0]                         dword_t;

  prod_t expected_products[$];

  // Rows of a times one word of b, accumulated into p with a carry word.
  // p[i+j] + a*b + carry never exceeds 2^128 - 1.
  function automatic prod_t schoolbook_product(logic mode, w256m_pkg::opnd_t a,
                                               w256m_pkg::opnd_t b);
    prod_t                          p;
    dword_t                         t;
    logic [w256m_pkg::WORD_W-1:0]   carry;
    p = '0;
    for (int i = 0; i < w256m_pkg::NWORDS; i++) begin
      carry = '0;
      for (int j = 0; j < w256m_pkg::NWORDS; j++) begin
        t = dword_t'(p[i+j]) + dword_t'(a[j]) * dword_t'(b[i]) + dword_t'(carry);
        p[i+j] = t[w256m_pkg::WORD_W-1:0];
        carry  = t[2*w256m_pkg::WORD_W-1:w256m_pkg::WORD_W];
      end
      p[i+w256m_pkg::NWORDS] = carry;
    end
    if (mode == w256m_pkg::ACT_LOW) begin
      for (int k = w256m_pkg::NWORDS; k < 2*w256m_pkg::NWORDS; k++) p[k] = '0;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [w256m_pkg::WORD_W-1:0] got,
                                 logic [w256m_pkg::WORD_W-1:0] want);
    $display("%0t ns: mismatch %s: got %h expected %h", $time, what, got, want);
    n_fail++;
  endtask

  initial begin
    n_fail    = 0;
    n_pending = 0;
  end

  always @(posedge clk) begin : watch
    prod_t got;
    prod_t want;
    if (rst_n) begin
      // retire first: a product can never belong to this cycle's operands
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.p_word7, out_ch.p_word6, out_ch.p_word5, out_ch.p_word4,
               out_ch.p_word3, out_ch.p_word2, out_ch.p_word1, out_ch.p_word0};
        if (expected_products.size() == 0) begin
          report_mismatch("product transaction with none expected", got[0], '0);
        end else begin
          want = expected_products.pop_front();
          for (int k = 0; k < 2*w256m_pkg::NWORDS; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("p_word%0d", k), got[k], want[k]);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_products.push_back(schoolbook_product(in_ch.action,
          {in_ch.a_word3, in_ch.a_word2, in_ch.a_word1, in_ch.a_word0},
          {in_ch.b_word3, in_ch.b_word2, in_ch.b_word1, in_ch.b_word0}));
      end
      n_pending = expected_products.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for wide_256_multiplier_core
// Drives directed corner operands, then bursts of random operand pairs in
// both modes, with random output stalls, one long output hold-off and one
// full drain. The product checker predicts and compares; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned N_RANDOM     = 1335;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int          LONG_HOLD    = 80;

  logic        clk;
  logic        rst_n;
  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned cycle_count = 0;
  int          hold_left   = 0;

  w256m_in_if  in_ch ();
  w256m_out_if out_ch ();

  wide_256_multiplier_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  w256m_product_checker i_product_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: stall style and its run length are drawn at random; a requested
  // hold-off overrides it
  initial begin : product_sink
    int stall_mode;
    int mode_left;
    out_ch.ready = 1'b0;
    stall_mode   = 0;
    mode_left    = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) >= 3);
          2: out_ch.ready <= (cycle_count % 4 != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  function automatic logic [w256m_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      3: return {32'b0, $urandom};
      4: return {32'hffff_ffff, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic w256m_pkg::opnd_t rand_opnd();
    w256m_pkg::opnd_t v;
    for (int k = 0; k < w256m_pkg::NWORDS; k++) v[k] = rand_word();
    // now and then a short operand, upper words clear
    if ($urandom_range(0, 7) == 0) begin
      for (int k = $urandom_range(1, w256m_pkg::NWORDS-1); k < w256m_pkg::NWORDS; k++) begin
        v[k] = '0;
      end
    end
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(input logic mode, input w256m_pkg::opnd_t a,
                         input w256m_pkg::opnd_t b);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= mode;
    in_ch.a_word0 <= a[0];
    in_ch.a_word1 <= a[1];
    in_ch.a_word2 <= a[2];
    in_ch.a_word3 <= a[3];
    in_ch.b_word0 <= b[0];
    in_ch.b_word1 <= b[1];
    in_ch.b_word2 <= b[2];
    in_ch.b_word3 <= b[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // n must be at least 1 so valid never drops and rises in one step
  task automatic idle(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle(1);
    while (n_pending != 0) @(negedge clk);
  endtask

  initial begin : operand_source
    w256m_pkg::opnd_t all_ones;
    w256m_pkg::opnd_t top_bit;
    w256m_pkg::opnd_t low_word_max;
    w256m_pkg::opnd_t alt_a;
    w256m_pkg::opnd_t alt_b;
    w256m_pkg::opnd_t ra;
    w256m_pkg::opnd_t rb;
    int unsigned      sent;
    int               burst;
    bit               quiet;
    bit               hold_done;
    bit               drain_done;

    in_ch.valid   = 1'b0;
    in_ch.action  = w256m_pkg::ACT_FULL;
    in_ch.a_word0 = '0;
    in_ch.a_word1 = '0;
    in_ch.a_word2 = '0;
    in_ch.a_word3 = '0;
    in_ch.b_word0 = '0;
    in_ch.b_word1 = '0;
    in_ch.b_word2 = '0;
    in_ch.b_word3 = '0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    all_ones     = '1;
    top_bit      = '0;
    top_bit[3][63] = 1'b1;
    low_word_max = '0;
    low_word_max[0] = '1;
    alt_a        = {w256m_pkg::NWORDS{64'haaaa_aaaa_aaaa_aaaa}};
    alt_b        = {w256m_pkg::NWORDS{64'h5555_5555_5555_5555}};
    ra           = rand_opnd();
    rb           = rand_opnd();

    // corners in both modes
    send_op(w256m_pkg::ACT_FULL, '0, '0);
    send_op(w256m_pkg::ACT_LOW, '0, '0);
    send_op(w256m_pkg::ACT_FULL, all_ones, all_ones);
    send_op(w256m_pkg::ACT_LOW, all_ones, all_ones);
    send_op(w256m_pkg::ACT_FULL, all_ones, w256m_pkg::opnd_t'(1));
    send_op(w256m_pkg::ACT_LOW, w256m_pkg::opnd_t'(1), all_ones);
    send_op(w256m_pkg::ACT_FULL, top_bit, top_bit);
    send_op(w256m_pkg::ACT_LOW, top_bit, top_bit);
    send_op(w256m_pkg::ACT_FULL, low_word_max, low_word_max);
    send_op(w256m_pkg::ACT_FULL, all_ones, w256m_pkg::opnd_t'(2));
    send_op(w256m_pkg::ACT_FULL, alt_a, alt_b);
    send_op(w256m_pkg::ACT_LOW, alt_b, alt_a);
    send_op(w256m_pkg::ACT_LOW, w256m_pkg::opnd_t'(1) << w256m_pkg::WORD_W, all_ones);
    send_op(w256m_pkg::ACT_FULL, all_ones, top_bit);
    // same operands in both modes: low words must agree
    send_op(w256m_pkg::ACT_FULL, ra, rb);
    send_op(w256m_pkg::ACT_LOW, ra, rb);
    wait_drained();

    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 16);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        send_op(logic'($urandom_range(0, 1)), rand_opnd(), rand_opnd());
        sent++;
      end
      // long output hold-off while operands keep coming
      if (!hold_done && sent >= 400) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= 850) begin
        wait_drained();
        drain_done = 1'b1;
      end else if (!quiet) begin
        idle($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
